/* rtl/pmf_pkg.sv */
package pmf_pkg;

  // default for the longest pattern the window holds
  localparam int unsigned DEF_MAX_PATTERN = 16;

  // fixed widths of the register file
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned PAT_BYTES = 16;
  localparam int unsigned PB_W      = 4;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned ADDR_W    = 2;

  // replacement character for masked bytes
  localparam logic [7:0] MASK_CHAR = 8'h2A;

  // register indexes
  typedef enum logic [ADDR_W-1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_PAT_LEN  = 2'd2
  } pmf_reg_e;

  // control handed to every cell of the window
  typedef struct packed {
    logic shift;
    logic hit;
  } pmf_cell_ctrl_t;

  // one output word
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pmf_word_t;

endpackage

/* rtl/pmf_cell.sv */
module pmf_cell import pmf_pkg::*; #(
  parameter int unsigned CW  = 5,
  parameter int unsigned IDX = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pmf_cell_ctrl_t ctrl_i,
  input  logic [CW-1:0]  len_i,
  input  logic [7:0]     pat_byte_i,
  input  logic [7:0]     byte_i,
  input  logic           mask_i,
  output logic           eq_o,
  output logic [7:0]     byte_o,
  output logic           mask_o,
  output logic [7:0]     byte_d_o,
  output logic           mask_d_o
);

  logic [7:0] byte_q, byte_d;
  logic       mask_q, mask_d;
  logic       active;

  // cell lies inside the compared span
  assign active = CW'(IDX) < len_i;

  // compare the byte that moves in this cycle
  assign eq_o = !active || (byte_i == pat_byte_i);

  // shift from the younger neighbor, masking on a hit
  always_comb begin
    byte_d = byte_q;
    mask_d = mask_q;
    if (ctrl_i.shift) begin
      byte_d = byte_i;
      mask_d = mask_i || (ctrl_i.hit && active);
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
    end
  end

  assign byte_o   = byte_q;
  assign mask_o   = mask_q;
  assign byte_d_o = byte_d;
  assign mask_d_o = mask_d;

endmodule

/* rtl/pmf_out_buf.sv */
module pmf_out_buf import pmf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  pmf_word_t word_i,
  output logic      ready_o,
  output logic      valid_o,
  input  logic      pop_i,
  output pmf_word_t word_o
);

  pmf_word_t  mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign ready_o = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign word_o  = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // pointers and fill level
  always_comb begin
    wr_d  = do_push ? !wr_q : wr_q;
    rd_d  = do_pop ? !rd_q : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // word storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= word_i;
    end
  end

endmodule

/* rtl/pattern_mask_filter.sv */
// channel | direction | handshake              | payload
// in      | input     | in_valid_i/in_ready_o  | data_byte_i, end_of_stream_i
// out     | output    | out_valid_o/out_ready_i| out_byte_o, out_last_o
// cfg     | input     | cfg_we_i               | cfg_addr_i, cfg_wdata_i
//
// one byte per cycle in steady state; once pattern length minus one bytes are held,
// every accepted byte pushes one word in the same cycle into a two-word output buffer,
// so each byte is held in the chain until pattern length minus one later bytes arrive.
// a byte marked end of stream, or a shortened pattern length, leaves surplus
// bytes that drain one word per cycle while input is held off and the buffer has room.
// reset clears fill, mask flags and the output buffer and sets the match distance to its maximum.
// a full output buffer stalls input.
module pattern_mask_filter import pmf_pkg::*; #(
  parameter int unsigned MAX_PATTERN = DEF_MAX_PATTERN
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_stream_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              out_last_o
);

  localparam int unsigned CW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // configuration registers
  logic [CFG_W-1:0] pat_low_q, pat_high_q;
  logic [LEN_W-1:0] pat_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
    end else if (cfg_we_i) begin
      case (pmf_reg_e'(cfg_addr_i))
        REG_PAT_LOW:  pat_low_q  <= cfg_wdata_i;
        REG_PAT_HIGH: pat_high_q <= cfg_wdata_i;
        REG_PAT_LEN:  pat_len_q  <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective length and bytes held back
  logic [CW-1:0] len, keep;
  assign len  = (pat_len_q > LEN_W'(MAX_PATTERN)) ? CW'(MAX_PATTERN) : pat_len_q[CW-1:0];
  assign keep = (len == '0) ? '0 : len - CW'(1);

  logic [8*PAT_BYTES-1:0] pat;
  assign pat = {pat_high_q, pat_low_q};

  // control state
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] dist_q, dist_d, dist_inc;
  logic          drain_q, drain_d;
  logic          flush_q, flush_d;
  logic          buf_ready, accept, drain_step, push, hit, emit;
  logic [CW-1:0] fill_inc, fill_dec;
  logic [IW-1:0] rd_idx;

  pmf_cell_ctrl_t     ctrl;
  logic [MAX_PATTERN-1:0] eq, mask_q, mask_d;
  logic [7:0]             byte_q [MAX_PATTERN];
  logic [7:0]             byte_d [MAX_PATTERN];

  assign in_ready_o = !drain_q && buf_ready;
  assign accept     = in_valid_i && in_ready_o;
  assign drain_step = drain_q && buf_ready;
  // an accepted byte releases a word once the window holds more than keep bytes, or when it ends the stream
  assign emit       = end_of_stream_i || (fill_inc > keep);
  assign push       = (accept && emit) || drain_step;

  assign fill_inc = fill_q + CW'(1);
  assign fill_dec = fill_q - CW'(1);
  assign dist_inc = (dist_q < CW'(MAX_PATTERN)) ? dist_q + CW'(1) : dist_q;

  // match over the newest len bytes of the shifted window
  assign hit = accept && (len != '0) && (fill_inc >= len) && (dist_inc >= len) && (&eq);

  assign ctrl.shift = accept;
  assign ctrl.hit   = hit;

  // chain of window cells, newest at index zero
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [7:0]       nb_byte;
    logic             nb_mask;
    logic [LEN_W-1:0] pidx;

    if (j == 0) begin : g_head
      assign nb_byte = data_byte_i;
      assign nb_mask = 1'b0;
    end else begin : g_body
      assign nb_byte = byte_q[j-1];
      assign nb_mask = mask_q[j-1];
    end

    // pattern byte aligned to this cell
    assign pidx = LEN_W'(len) - LEN_W'(1) - LEN_W'(j);

    pmf_cell #(
      .CW (CW),
      .IDX(j)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .len_i     (len),
      .pat_byte_i(pat[8*pidx[PB_W-1:0] +: 8]),
      .byte_i    (nb_byte),
      .mask_i    (nb_mask),
      .eq_o      (eq[j]),
      .byte_o    (byte_q[j]),
      .mask_o    (mask_q[j]),
      .byte_d_o  (byte_d[j]),
      .mask_d_o  (mask_d[j])
    );
  end

  // oldest held byte after this cycle's shift
  pmf_word_t word;
  assign rd_idx    = accept ? fill_q[IW-1:0] : fill_dec[IW-1:0];
  assign word.data = mask_d[rd_idx] ? MASK_CHAR : byte_d[rd_idx];
  assign word.last = accept ? (end_of_stream_i && (fill_q == '0))
                            : (flush_q && (fill_q == CW'(1)));

  // next fill, match distance and drain mode
  always_comb begin
    fill_d  = fill_q;
    dist_d  = dist_q;
    drain_d = drain_q;
    flush_d = flush_q;
    if (accept) begin
      fill_d  = emit ? fill_q : fill_inc;
      dist_d  = end_of_stream_i ? CW'(MAX_PATTERN) : (hit ? '0 : dist_inc);
      flush_d = end_of_stream_i;
      drain_d = end_of_stream_i ? (fill_q != '0) : (fill_q > keep);
    end else if (drain_step) begin
      fill_d  = fill_dec;
      drain_d = flush_q ? (fill_dec != '0) : (fill_dec > keep);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      dist_q  <= CW'(MAX_PATTERN);
      drain_q <= 1'b0;
      flush_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      dist_q  <= dist_d;
      drain_q <= drain_d;
      flush_q <= flush_d;
    end
  end

  // output words
  pmf_word_t out_word;

  pmf_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .word_i (word),
    .ready_o(buf_ready),
    .valid_o(out_valid_o),
    .pop_i  (out_ready_i),
    .word_o (out_word)
  );

  assign out_byte_o = out_word.data;
  assign out_last_o = out_word.last;

endmodule

/* test/pmf_checker.sv */
// watches the config port and both word channels, predicts the masked stream
// and compares every accepted output word against the oldest prediction
module pmf_checker import pmf_pkg::*; #(
  parameter int unsigned MAX_PATTERN = DEF_MAX_PATTERN
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_stream_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [7:0]        out_byte_i,
  input  logic              out_last_i,
  input  logic              report_i,
  output int unsigned       pending_o,
  output int unsigned       checked_o,
  output int unsigned       err_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the register file
  logic [63:0]      pat_lo_q;
  logic [63:0]      pat_hi_q;
  logic [LEN_W-1:0] pat_len_q;

  // shadow window of held bytes
  logic [7:0]  win_byte [PAT_BYTES];
  bit          win_mask [PAT_BYTES];
  int unsigned win_fill;
  int unsigned since_match;

  pmf_word_t   expected_words [$];
  pmf_word_t   received_words [$];
  int unsigned mism_cnt;
  int unsigned word_cnt;
  bit          reported;

  // pattern length in force, clamped to the window
  function automatic int unsigned active_len();
    int unsigned n;
    n = pat_len_q;
    if (n > MAX_PATTERN) n = MAX_PATTERN;
    if (n > PAT_BYTES) n = PAT_BYTES;
    return n;
  endfunction

  function automatic logic [7:0] pattern_at(int unsigned i);
    return (i < 8) ? pat_lo_q[8*i +: 8] : pat_hi_q[8*(i-8) +: 8];
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < PAT_BYTES; i++) begin
      win_byte[i] = '0;
      win_mask[i] = 1'b0;
    end
    win_fill    = 0;
    since_match = MAX_PATTERN;
  endfunction

  // oldest held byte leaves as one word, asterisk if masked
  function automatic void release_oldest(bit last);
    pmf_word_t w;
    w.data = win_mask[0] ? MASK_CHAR : win_byte[0];
    w.last = last;
    expected_words.push_back(w);
    for (int unsigned i = 1; i < win_fill; i++) begin
      win_byte[i-1] = win_byte[i];
      win_mask[i-1] = win_mask[i];
    end
    win_fill--;
  endfunction

  // one accepted byte: shift in, try a greedy match at the tail, release
  function automatic void take_byte(logic [7:0] b, logic eos);
    int unsigned len;
    int unsigned keep;
    int unsigned base;
    bit          hit;
    len  = active_len();
    keep = (len == 0) ? 0 : len - 1;
    if (win_fill >= PAT_BYTES) win_fill = PAT_BYTES - 1;
    win_byte[win_fill] = b;
    win_mask[win_fill] = 1'b0;
    win_fill++;
    if (since_match < MAX_PATTERN) since_match++;
    // no match may overlap the previous one
    if (len > 0 && win_fill >= len && since_match >= len) begin
      base = win_fill - len;
      hit  = 1'b1;
      for (int unsigned i = 0; i < len; i++) begin
        if (win_byte[base+i] != pattern_at(i)) hit = 1'b0;
      end
      if (hit) begin
        for (int unsigned i = 0; i < len; i++) win_mask[base+i] = 1'b1;
        since_match = 0;
      end
    end
    if (eos) begin
      while (win_fill > 0) release_oldest(win_fill == 1);
      clear_window();
    end else begin
      while (win_fill > keep) release_oldest(1'b0);
    end
  endfunction

  // pair received words with predictions in order
  function automatic void compare_words();
    pmf_word_t exp_w;
    pmf_word_t got_w;
    while (expected_words.size() > 0 && received_words.size() > 0) begin
      exp_w = expected_words.pop_front();
      got_w = received_words.pop_front();
      word_cnt++;
      if (got_w.data !== exp_w.data) begin
        mism_cnt++;
        $display("%0t: out_byte mismatch, expected %h, got %h", $time, exp_w.data, got_w.data);
      end
      if (got_w.last !== exp_w.last) begin
        mism_cnt++;
        $display("%0t: out_last mismatch, expected %b, got %b", $time, exp_w.last, got_w.last);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  = '0;
      pat_hi_q  = '0;
      pat_len_q = '0;
      clear_window();
      expected_words.delete();
      received_words.delete();
      mism_cnt  = 0;
      word_cnt  = 0;
      reported  = 1'b0;
      pending_o <= 0;
      checked_o <= 0;
      err_cnt_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) take_byte(data_byte_i, end_of_stream_i);
      if (out_valid_i && out_ready_i) begin
        received_words.push_back('{data: out_byte_i, last: out_last_i});
      end
      // a register write takes effect from the next byte on
      if (cfg_we_i) begin
        case (pmf_reg_e'(cfg_addr_i))
          REG_PAT_LOW:  pat_lo_q  = cfg_wdata_i;
          REG_PAT_HIGH: pat_hi_q  = cfg_wdata_i;
          REG_PAT_LEN:  pat_len_q = cfg_wdata_i[LEN_W-1:0];
          default: ;
        endcase
      end
      compare_words();
      // anything left on either side at the end is a failure
      if (report_i && !reported) begin
        reported = 1'b1;
        if (expected_words.size() != 0) begin
          $display("%0t: %0d expected words never arrived, first expected %h last %b",
                   $time, expected_words.size(), expected_words[0].data,
                   expected_words[0].last);
          mism_cnt += expected_words.size();
        end
        if (received_words.size() != 0) begin
          $display("%0t: %0d words arrived with nothing expected, first got %h last %b",
                   $time, received_words.size(), received_words[0].data,
                   received_words[0].last);
          mism_cnt += received_words.size();
        end
      end
      pending_o <= expected_words.size();
      checked_o <= word_cnt;
      err_cnt_o <= mism_cnt;
    end
  end

endmodule

/* test/pattern_mask_filter_tb.sv */
module pattern_mask_filter_tb import pmf_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_BYTES = 400;
  // output buffer plus a flush of up to 15 held words
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned LONG_HOLD    = 120;
  localparam int unsigned END_LIMIT    = 20000;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  pmf_reg_e         cfg_addr  = REG_PAT_LOW;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic [7:0]       in_data   = '0;
  logic             in_eos    = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       out_data;
  logic             out_last;
  logic             report    = 1'b0;
  int unsigned      pending;
  int unsigned      checked;
  int unsigned      err_cnt;

  // stimulus state
  logic [7:0]  pat_sym [PAT_BYTES];
  logic [7:0]  alpha [3];
  int unsigned pat_len_cur = 0;
  bit          steady = 1'b0;
  bit          long_hold_req = 1'b0;
  bit          long_hold_done = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned streams_sent = 0;
  int unsigned cfg_writes = 0;

  always #5 clk = ~clk;

  pattern_mask_filter i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .data_byte_i     (in_data),
    .end_of_stream_i (in_eos),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .out_byte_o      (out_data),
    .out_last_o      (out_last)
  );

  pmf_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .data_byte_i     (in_data),
    .end_of_stream_i (in_eos),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_byte_i      (out_data),
    .out_last_i      (out_last),
    .report_i        (report),
    .pending_o       (pending),
    .checked_o       (checked),
    .err_cnt_o       (err_cnt)
  );

  // mostly short gaps, now and then a long one, none in steady stretches
  function automatic int unsigned idle_cycles();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin : out_side
    int unsigned run;
    forever begin
      if (long_hold_req && !long_hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end else if (steady) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        run = idle_cycles();
        if (run > 0) begin
          out_ready <= 1'b0;
          repeat (run) @(posedge clk);
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= b;
    in_eos   <= eos;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender holds off until every predicted word is out, then lets the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input pmf_reg_e idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  task automatic program_pattern(input logic [4:0] len);
    logic [63:0] lo;
    logic [63:0] hi;
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = pat_sym[i];
      hi[8*i +: 8] = pat_sym[8+i];
    end
    wait_idle();
    cfg_write(REG_PAT_LOW, lo);
    cfg_write(REG_PAT_HIGH, hi);
    cfg_write(REG_PAT_LEN, CFG_W'(len));
    pat_len_cur = len;
  endtask

  // one stream, end of stream on its last byte, optional length change inside
  task automatic send_text(input logic [7:0] text [$], input int change_at,
                           input logic [4:0] new_len);
    for (int i = 0; i < text.size(); i++) begin
      if (i == change_at) begin
        wait_idle();
        cfg_write(REG_PAT_LEN, CFG_W'(new_len));
        pat_len_cur = new_len;
      end
      send_byte(text[i], i == text.size() - 1);
    end
    streams_sent++;
  endtask

  // text mostly built from whole or partial pattern copies and the alphabet
  task automatic build_text(ref logic [7:0] text [$], input int unsigned n);
    int unsigned r;
    int unsigned eff;
    int unsigned part;
    eff = (pat_len_cur > PAT_BYTES) ? PAT_BYTES : pat_len_cur;
    text.delete();
    while (text.size() < n) begin
      r = $urandom_range(99);
      if (r < 40 && eff > 0) begin
        for (int unsigned i = 0; i < eff; i++) text.push_back(pat_sym[i]);
      end else if (r < 60 && eff > 1) begin
        part = $urandom_range(1, eff - 1);
        for (int unsigned i = 0; i < part; i++) text.push_back(pat_sym[i]);
      end else if (r < 90) begin
        text.push_back(alpha[$urandom_range(2)]);
      end else begin
        text.push_back(8'($urandom));
      end
    end
  endtask

  task automatic random_phase();
    int unsigned r;
    int unsigned kind;
    int          change_at;
    logic [4:0]  len;
    logic [7:0]  text [$];
    r = $urandom_range(99);
    if (r < 10)      len = 5'd0;
    else if (r < 65) len = 5'($urandom_range(1, 4));
    else if (r < 85) len = 5'($urandom_range(5, 15));
    else if (r < 93) len = 5'd16;
    else             len = 5'($urandom_range(17, 31));
    for (int i = 0; i < 3; i++) alpha[i] = 8'($urandom);
    // occasionally all-zero or all-ones registers
    kind = $urandom_range(19);
    for (int i = 0; i < PAT_BYTES; i++) begin
      if (kind == 0)      pat_sym[i] = 8'hFF;
      else if (kind == 1) pat_sym[i] = 8'h00;
      else if (i < len)   pat_sym[i] = alpha[$urandom_range(2)];
      else                pat_sym[i] = 8'($urandom);
    end
    if (kind < 2) alpha[0] = pat_sym[0];
    steady = ($urandom_range(5) == 0);
    program_pattern(len);
    repeat ($urandom_range(1, 2)) begin
      build_text(text, ($urandom_range(9) == 0) ? $urandom_range(25, 48)
                                                : $urandom_range(1, 24));
      change_at = -1;
      if ($urandom_range(6) == 0 && text.size() > 1) begin
        change_at = int'($urandom_range(1, text.size() - 1));
      end
      send_text(text, change_at, 5'($urandom_range(0, 31)));
    end
    steady = 1'b0;
  endtask

  initial begin : stimulus
    int unsigned guard;
    int unsigned first_random;
    logic [7:0]  text [$];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: empty pattern, bytes pass straight through
    text = '{8'h00, 8'hFF, 8'h2A};
    send_text(text, -1, '0);
    text = '{8'h55};
    send_text(text, -1, '0);

    // "aa" over a run of a: matches must not overlap
    for (int i = 0; i < PAT_BYTES; i++) pat_sym[i] = 8'hFF;
    pat_sym[0] = 8'h61;
    pat_sym[1] = 8'h61;
    program_pattern(5'd2);
    text = '{8'h61, 8'h61, 8'h61, 8'h61, 8'h61};
    send_text(text, -1, '0);

    // all-ones registers
    for (int i = 0; i < PAT_BYTES; i++) pat_sym[i] = 8'hFF;
    program_pattern(5'd3);
    text = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_text(text, -1, '0);

    // oversized length, stream shorter than the pattern
    for (int i = 0; i < PAT_BYTES; i++) pat_sym[i] = 8'h00;
    program_pattern(5'd31);
    text = '{8'h00, 8'h00};
    send_text(text, -1, '0);

    // length shortened while bytes are held
    pat_sym[0] = 8'h61;
    pat_sym[1] = 8'h62;
    pat_sym[2] = 8'h61;
    pat_sym[3] = 8'h62;
    program_pattern(5'd4);
    text = '{8'h61, 8'h62, 8'h61, 8'h62, 8'h62};
    send_text(text, 3, 5'd2);

    // long receiver hold-off while the sender keeps pushing
    first_random = bytes_sent;
    wait_idle();
    for (int i = 0; i < 3; i++) alpha[i] = 8'($urandom);
    for (int i = 0; i < PAT_BYTES; i++) pat_sym[i] = alpha[$urandom_range(2)];
    steady = 1'b1;
    long_hold_req = 1'b1;
    program_pattern(5'd16);
    build_text(text, 60);
    send_text(text, -1, '0);
    steady = 1'b0;

    while (bytes_sent < first_random + RANDOM_BYTES) random_phase();

    // drain and verdict
    in_valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (pending != 0 && guard < END_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (pending != 0) begin
      $display("%0t: %0d words still outstanding at the end", $time, pending);
      $display("Regression FAIL");
      $finish;
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      report <= 1'b1;
      repeat (2) @(posedge clk);
      $display("sent %0d bytes in %0d streams (%0d random), %0d register writes",
               bytes_sent, streams_sent, bytes_sent - first_random, cfg_writes);
      $display("compared %0d output words, with one %0d-cycle output hold-off",
               checked, LONG_HOLD);
      if (err_cnt == 0) begin
        $display("Regression PASS");
      end else begin
        $display("Regression FAIL");
      end
      $finish;
    end
  end

  // hang guard
  initial begin : watchdog
    #5ms;
    $display("%0t: timeout", $time);
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* files.f */
rtl/pmf_pkg.sv
rtl/pmf_cell.sv
rtl/pmf_out_buf.sv
rtl/pattern_mask_filter.sv
test/pmf_checker.sv
test/pattern_mask_filter_tb.sv
